@@ rtl/hsv_pkg.sv @@
// Package for the HSV to RGB converter: fixed-point constants, sector codes
// and the pipeline load struct. No dependencies.
package hsv_pkg;

  // Q0.16 components; one is 2^16 and needs a 17th bit
  localparam int unsigned CompW = 17;
  localparam logic [CompW-1:0] QOne = 17'h10000;

  localparam int unsigned ChanW = 8;
  localparam logic [ChanW-1:0] SatFull = 8'd255;

  // Product (one - c) * (255 - sat) is below 2^24
  localparam int unsigned ProdW = 24;

  // floor(x / 255) = (x * RecipMul) >> RecipShift, exact for x < 2^24
  localparam int unsigned RecipShift = 32;
  localparam int unsigned RecipW = 25;
  localparam logic [RecipW-1:0] RecipMul = 25'h1010102;
  localparam int unsigned RecipProdW = ProdW + RecipW;

  // Hue sectors, 60 degrees each
  typedef enum logic [2:0] {
    SEC_RED_GREEN_UP   = 3'd0,
    SEC_RED_DOWN       = 3'd1,
    SEC_GREEN_BLUE_UP  = 3'd2,
    SEC_GREEN_DOWN     = 3'd3,
    SEC_BLUE_RED_UP    = 3'd4,
    SEC_BLUE_DOWN      = 3'd5
  } sector_e;

  // Per-stage load strobes, one for each register stage
  typedef struct packed {
    logic load_sec;
    logic load_mul;
    logic load_div;
    logic load_sum;
    logic load_out;
  } pipe_ctrl_t;

endpackage

@@ rtl/hsv_in_if.sv @@
// Input channel of the HSV to RGB converter: valid/ready plus one HSV colour.
// Depends on hsv_pkg for the channel width.
interface hsv_in_if;
  logic                           valid;
  logic                           ready;
  logic [15:0]                    hue;
  logic [hsv_pkg::ChanW-1:0]      saturation;
  logic [hsv_pkg::ChanW-1:0]      brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

@@ rtl/hsv_rgb_if.sv @@
// Output channel of the HSV to RGB converter: valid/ready plus one RGB triple.
// Depends on hsv_pkg for the channel width.
interface hsv_rgb_if;
  logic                      valid;
  logic                      ready;
  logic [hsv_pkg::ChanW-1:0] red;
  logic [hsv_pkg::ChanW-1:0] green;
  logic [hsv_pkg::ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/hsv_to_rgb_converter.sv @@
// HSV to RGB converter (hexcone), five-stage pipeline.
// Depends on hsv_pkg, hsv_in_if, hsv_rgb_if, hsv_sector and hsv_lane.
//
// Usage:
//   hsv_i  : sink channel, one request per colour: hue (Q0.16 fraction of the
//            circle, low HUE_BITS bits used), saturation and brightness (0..255).
//   rgb_o  : source channel, one red/green/blue triple per request, in order.
//   Order: an accepted request moves through the sector, product, divide, sum
//     and output registers; rgb_o.valid rises once it reaches the output stage.
//   Throughput: one request per cycle while rgb_o.ready is high; every stage is
//     a register stage with its own valid bit, and /255 is a reciprocal multiply.
//   Stall: when rgb_o.ready is low, stages fill from the output backwards;
//     hsv_i.ready drops only once all five stages hold a request. Empty
//     stages close up so bubbles are squeezed out. Nothing is dropped or
//     repeated.
//   Reset: rst_ni low clears all valid bits; the pipeline comes up empty and
//     ready. No configuration registers.
module hsv_to_rgb_converter #(
  parameter int unsigned HUE_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hsv_in_if.sink       hsv_i,
  hsv_rgb_if.source    rgb_o
);

  localparam int unsigned NumStages = 5;

  logic [NumStages-1:0]      valid_q;
  logic [NumStages-1:0]      stage_rdy;
  logic [NumStages-1:0]      valid_in;
  hsv_pkg::pipe_ctrl_t       ctrl;

  logic [hsv_pkg::CompW-1:0] red_c, green_c, blue_c;
  logic [hsv_pkg::ChanW-1:0] sat_inv, val;

  // A stage can take a request when empty or when the next stage moves on
  always_comb begin
    stage_rdy[NumStages-1] = ~valid_q[NumStages-1] | rgb_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_rdy[k] = ~valid_q[k] | stage_rdy[k+1];
    end
  end

  assign valid_in = {valid_q[NumStages-2:0], hsv_i.valid};

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (stage_rdy[k]) begin
          valid_q[k] <= valid_in[k];
        end
      end
    end
  end

  // Load payload only when a valid request moves in
  assign ctrl.load_sec = stage_rdy[0] & valid_in[0];
  assign ctrl.load_mul = stage_rdy[1] & valid_in[1];
  assign ctrl.load_div = stage_rdy[2] & valid_in[2];
  assign ctrl.load_sum = stage_rdy[3] & valid_in[3];
  assign ctrl.load_out = stage_rdy[4] & valid_in[4];

  assign hsv_i.ready = stage_rdy[0];
  assign rgb_o.valid = valid_q[NumStages-1];

  hsv_sector #(
    .HUE_BITS (HUE_BITS)
  ) u_sector (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .hue_i        (hsv_i.hue),
    .saturation_i (hsv_i.saturation),
    .brightness_i (hsv_i.brightness),
    .red_c_o      (red_c),
    .green_c_o    (green_c),
    .blue_c_o     (blue_c),
    .sat_inv_o    (sat_inv),
    .val_o        (val)
  );

  hsv_lane u_lane_red (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .comp_i    (red_c),
    .sat_inv_i (sat_inv),
    .val_i     (val),
    .level_o   (rgb_o.red)
  );

  hsv_lane u_lane_green (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .comp_i    (green_c),
    .sat_inv_i (sat_inv),
    .val_i     (val),
    .level_o   (rgb_o.green)
  );

  hsv_lane u_lane_blue (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .comp_i    (blue_c),
    .sat_inv_i (sat_inv),
    .val_i     (val),
    .level_o   (rgb_o.blue)
  );

endmodule

@@ rtl/hsv_sector.sv @@
// First pipeline stage: splits the hue into sector and ramp and registers the
// three Q0.16 components, 255 - saturation and the brightness. Depends on hsv_pkg.
module hsv_sector #(
  parameter int unsigned HUE_BITS = 16
) (
  input  logic                              clk_i,
  input  hsv_pkg::pipe_ctrl_t               ctrl_i,
  input  logic [15:0]                       hue_i,
  input  logic [hsv_pkg::ChanW-1:0]         saturation_i,
  input  logic [hsv_pkg::ChanW-1:0]         brightness_i,
  output logic [hsv_pkg::CompW-1:0]         red_c_o,
  output logic [hsv_pkg::CompW-1:0]         green_c_o,
  output logic [hsv_pkg::CompW-1:0]         blue_c_o,
  output logic [hsv_pkg::ChanW-1:0]         sat_inv_o,
  output logic [hsv_pkg::ChanW-1:0]         val_o
);

  localparam int unsigned TW = HUE_BITS + 3;

  logic [HUE_BITS-1:0]        hue_w;
  logic [TW-1:0]              t_w;
  hsv_pkg::sector_e           sector_w;
  logic [hsv_pkg::CompW-1:0]  ramp_w;
  logic [hsv_pkg::CompW-1:0]  fall_w;
  logic [hsv_pkg::CompW-1:0]  red_d, green_d, blue_d;
  logic [hsv_pkg::CompW-1:0]  red_q, green_q, blue_q;
  logic [hsv_pkg::ChanW-1:0]  sat_inv_q, val_q;

  // Scale hue by six: integer part picks the sector, fraction is the ramp
  assign hue_w    = hue_i[HUE_BITS-1:0];
  assign t_w      = (TW'(hue_w) << 2) + (TW'(hue_w) << 1);
  assign sector_w = hsv_pkg::sector_e'(t_w[TW-1:HUE_BITS]);
  assign ramp_w   = hsv_pkg::CompW'(16'(t_w[HUE_BITS-1:0]) << (16 - HUE_BITS));
  assign fall_w   = hsv_pkg::QOne - ramp_w;

  // Select the component pattern for the sector
  always_comb begin
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    case (sector_w)
      hsv_pkg::SEC_RED_GREEN_UP: begin
        red_d   = hsv_pkg::QOne;
        green_d = ramp_w;
      end
      hsv_pkg::SEC_RED_DOWN: begin
        red_d   = fall_w;
        green_d = hsv_pkg::QOne;
      end
      hsv_pkg::SEC_GREEN_BLUE_UP: begin
        green_d = hsv_pkg::QOne;
        blue_d  = ramp_w;
      end
      hsv_pkg::SEC_GREEN_DOWN: begin
        green_d = fall_w;
        blue_d  = hsv_pkg::QOne;
      end
      hsv_pkg::SEC_BLUE_RED_UP: begin
        red_d   = ramp_w;
        blue_d  = hsv_pkg::QOne;
      end
      default: begin
        red_d   = hsv_pkg::QOne;
        blue_d  = fall_w;
      end
    endcase
  end

  // Capture the stage when the pipeline advances
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_sec) begin
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
      sat_inv_q <= hsv_pkg::SatFull - saturation_i;
      val_q     <= brightness_i;
    end
  end

  assign red_c_o   = red_q;
  assign green_c_o = green_q;
  assign blue_c_o  = blue_q;
  assign sat_inv_o = sat_inv_q;
  assign val_o     = val_q;

endmodule

@@ rtl/hsv_lane.sv @@
// One colour lane, stages two to five: desaturation product, divide by 255
// through a reciprocal multiply, add back, brightness scale. Depends on hsv_pkg.
module hsv_lane (
  input  logic                      clk_i,
  input  hsv_pkg::pipe_ctrl_t       ctrl_i,
  input  logic [hsv_pkg::CompW-1:0] comp_i,
  input  logic [hsv_pkg::ChanW-1:0] sat_inv_i,
  input  logic [hsv_pkg::ChanW-1:0] val_i,
  output logic [hsv_pkg::ChanW-1:0] level_o
);

  logic [hsv_pkg::CompW-1:0]      gap_w;
  logic [hsv_pkg::ProdW-1:0]      prod_d, prod_q;
  logic [hsv_pkg::CompW-1:0]      comp2_q, comp3_q;
  logic [hsv_pkg::ChanW-1:0]      val2_q, val3_q, val4_q;
  logic [hsv_pkg::RecipProdW-1:0] recip_w;
  logic [hsv_pkg::CompW-1:0]      quot_q;
  logic [hsv_pkg::CompW-1:0]      sum_q;
  logic [hsv_pkg::CompW+hsv_pkg::ChanW-1:0] scale_w;
  logic [hsv_pkg::ChanW-1:0]      level_q;

  // Distance to one, times the saturation complement
  assign gap_w  = hsv_pkg::QOne - comp_i;
  assign prod_d = hsv_pkg::ProdW'(gap_w) * hsv_pkg::ProdW'(sat_inv_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_mul) begin
      prod_q  <= prod_d;
      comp2_q <= comp_i;
      val2_q  <= val_i;
    end
  end

  // Divide by 255 with the reciprocal
  assign recip_w = hsv_pkg::RecipProdW'(prod_q) * hsv_pkg::RecipProdW'(hsv_pkg::RecipMul);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_div) begin
      quot_q  <= recip_w[hsv_pkg::RecipShift +: hsv_pkg::CompW];
      comp3_q <= comp2_q;
      val3_q  <= val2_q;
    end
  end

  // Pull the component towards one
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_sum) begin
      sum_q  <= comp3_q + quot_q;
      val4_q <= val3_q;
    end
  end

  // Scale by brightness and keep the integer byte
  assign scale_w = (hsv_pkg::CompW + hsv_pkg::ChanW)'(sum_q) *
                   (hsv_pkg::CompW + hsv_pkg::ChanW)'(val4_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      level_q <= scale_w[16 +: hsv_pkg::ChanW];
    end
  end

  assign level_o = level_q;

endmodule
